### rtl/tcw_pkg.sv
// shared constants, command and status types for the text console writer
package tcw_pkg;

    localparam int DEF_ROWS = 25;
    localparam int DEF_COLS = 80;

    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int COLUMN_W = 7;
    localparam int LINE_W   = 5;
    localparam int CURSOR_W = 11;
    localparam int CELL_DW  = CHAR_W + ATTR_W;

    localparam logic [CHAR_W-1:0] NEWLINE_CHAR       = 8'd10;
    localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RESET = 8'h0f;

    localparam logic OP_PRINT = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic capture;
        logic select;
        logic calc_addr;
        logic access;
        logic sweep_start;
        logic sweep_step;
        logic sweep_zero;
        logic result;
    } t_cmd;

    typedef struct packed {
        logic is_read;
        logic wraps;
        logic sweep_last;
        logic out_busy;
    } t_status;

endpackage

### rtl/tcw_ctrl.sv
// controller state machine for the text console writer
module tcw_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  tcw_pkg::t_status i_status,
    output logic             o_ready,
    output tcw_pkg::t_cmd    o_cmd
);

    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_SEL     = 8'b0000_0100,
        S_MUL     = 8'b0000_1000,
        S_ACCESS  = 8'b0001_0000,
        S_SCR_PRE = 8'b0010_0000,
        S_SCROLL  = 8'b0100_0000,
        S_RESULT  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.sweep_step = 1'b1;
                o_cmd.sweep_zero = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SEL;
                end
            end
            S_SEL: begin
                o_cmd.select = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.calc_addr = 1'b1;
                n_state         = S_ACCESS;
            end
            S_ACCESS: begin
                o_cmd.access = 1'b1;
                if (!i_status.is_read && i_status.wraps) begin
                    n_state = S_SCR_PRE;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_SCR_PRE: begin
                o_cmd.sweep_start = 1'b1;
                n_state           = S_SCROLL;
            end
            S_SCROLL: begin
                o_cmd.sweep_step = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!i_status.out_busy) begin
                    o_cmd.result = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/tcw_dp.sv
// datapath for the text console writer: screen memory, cursor and result registers
module tcw_dp #(
    parameter int ROWS = tcw_pkg::DEF_ROWS,
    parameter int COLS = tcw_pkg::DEF_COLS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tcw_pkg::t_cmd                 i_cmd,
    output tcw_pkg::t_status              o_status,
    input  logic                          i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]    i_cfg_data,
    input  logic                          i_op,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_character,
    input  logic [tcw_pkg::COLUMN_W-1:0]  i_column,
    input  logic [tcw_pkg::LINE_W-1:0]    i_line,
    input  logic                          i_use_position,
    input  logic [tcw_pkg::ATTR_W-1:0]    i_attribute,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [tcw_pkg::CURSOR_W-1:0]  o_cursor_cell,
    output logic                          o_scrolled,
    output logic [tcw_pkg::CHAR_W-1:0]    o_read_character,
    output logic [tcw_pkg::ATTR_W-1:0]    o_read_attribute
);

    localparam int CELLS  = ROWS * COLS;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int WIDE_W = ADDR_W + 1;
    localparam int IDX_W  = (ADDR_W > tcw_pkg::CURSOR_W) ? ADDR_W : tcw_pkg::CURSOR_W;
    localparam int CMPC_W = tcw_pkg::COLUMN_W + 3;
    localparam int CMPL_W = tcw_pkg::LINE_W + 3;

    logic [tcw_pkg::CELL_DW-1:0] mem [CELLS];

    logic                         r_op;
    logic [tcw_pkg::CHAR_W-1:0]   r_ch;
    logic [tcw_pkg::COLUMN_W-1:0] r_col_in;
    logic [tcw_pkg::LINE_W-1:0]   r_line_in;
    logic                         r_use_pos;
    logic [tcw_pkg::ATTR_W-1:0]   r_attr;
    logic [tcw_pkg::ATTR_W-1:0]   r_default;

    logic [ROW_W-1:0]  r_trow;
    logic [COL_W-1:0]  r_tcol;
    logic [ADDR_W-1:0] r_addr;
    logic [ROW_W-1:0]  r_cur_row;
    logic [COL_W-1:0]  r_cur_col;
    logic              r_scr;
    logic [ADDR_W-1:0] r_ptr;
    logic [tcw_pkg::CELL_DW-1:0] r_rdata;

    logic                         r_out_valid;
    logic [tcw_pkg::CURSOR_W-1:0] r_cell;
    logic                         r_scr_o;
    logic [tcw_pkg::CHAR_W-1:0]   r_rch;
    logic [tcw_pkg::ATTR_W-1:0]   r_rattr;

    logic [ROW_W-1:0]  sel_row;
    logic [COL_W-1:0]  sel_col;
    logic              is_newline;
    logic              col_last;
    logic              row_last;
    logic [tcw_pkg::ATTR_W-1:0] eff_attr;
    logic [WIDE_W-1:0] pref_addr;
    logic              pref_ok;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [tcw_pkg::CELL_DW-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic [IDX_W-1:0]  cur_idx;

    assign is_newline = (r_ch == tcw_pkg::NEWLINE_CHAR);
    assign col_last   = (r_tcol == COL_W'(COLS - 1));
    assign row_last   = (r_trow == ROW_W'(ROWS - 1));
    assign eff_attr   = (r_attr == '0) ? r_default : r_attr;

    always_comb begin
        if (!r_use_pos) begin
            sel_row = r_cur_row;
            sel_col = r_cur_col;
        end else begin
            if (CMPL_W'(r_line_in) >= CMPL_W'(ROWS)) begin
                sel_row = ROW_W'(ROWS - 1);
            end else begin
                sel_row = ROW_W'(r_line_in);
            end
            if (CMPC_W'(r_col_in) >= CMPC_W'(COLS)) begin
                sel_col = COL_W'(COLS - 1);
            end else begin
                sel_col = COL_W'(r_col_in);
            end
        end
        if (r_op == tcw_pkg::OP_READ) begin
            if (CMPL_W'(r_line_in) >= CMPL_W'(ROWS)) begin
                sel_row = ROW_W'(ROWS - 1);
            end else begin
                sel_row = ROW_W'(r_line_in);
            end
            if (CMPC_W'(r_col_in) >= CMPC_W'(COLS)) begin
                sel_col = COL_W'(COLS - 1);
            end else begin
                sel_col = COL_W'(r_col_in);
            end
        end else if (is_newline) begin
            sel_col = COL_W'(COLS - 1);
        end
    end

    // next read address during a scroll sweep
    assign pref_addr = WIDE_W'(r_ptr) + WIDE_W'(COLS + 1);
    assign pref_ok   = (pref_addr < WIDE_W'(CELLS));

    always_comb begin
        we    = 1'b0;
        waddr = r_ptr;
        wdata = '0;
        if (i_cmd.sweep_step) begin
            we = 1'b1;
            if (!i_cmd.sweep_zero && (WIDE_W'(r_ptr) < WIDE_W'(CELLS - COLS))) begin
                wdata = r_rdata;
            end
        end else if (i_cmd.access && (r_op == tcw_pkg::OP_PRINT) && !is_newline) begin
            we    = 1'b1;
            waddr = r_addr;
            wdata = {eff_attr, r_ch};
        end
    end

    always_comb begin
        re    = 1'b0;
        raddr = r_addr;
        if (i_cmd.sweep_start) begin
            re    = 1'b1;
            raddr = ADDR_W'(COLS);
        end else if (i_cmd.sweep_step && !i_cmd.sweep_zero) begin
            re    = pref_ok;
            raddr = pref_addr[ADDR_W-1:0];
        end else if (i_cmd.access && (r_op == tcw_pkg::OP_READ)) begin
            re = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= i_op;
            r_ch      <= i_character;
            r_col_in  <= i_column;
            r_line_in <= i_line;
            r_use_pos <= i_use_position;
            r_attr    <= i_attribute;
        end
        if (i_cmd.select) begin
            r_trow <= sel_row;
            r_tcol <= sel_col;
        end
        if (i_cmd.calc_addr) begin
            r_addr <= ADDR_W'(r_trow) * ADDR_W'(COLS) + ADDR_W'(r_tcol);
        end
    end

    assign cur_idx = IDX_W'(r_cur_row) * IDX_W'(COLS) + IDX_W'(r_cur_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default   <= tcw_pkg::DEFAULT_ATTR_RESET;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_scr       <= 1'b0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_default <= i_cfg_data;
            end
            if (i_cmd.access) begin
                r_scr <= (r_op == tcw_pkg::OP_PRINT) && col_last && row_last;
                if (r_op == tcw_pkg::OP_PRINT) begin
                    if (col_last) begin
                        r_cur_col <= '0;
                        if (!row_last) begin
                            r_cur_row <= r_trow + ROW_W'(1);
                        end else begin
                            r_cur_row <= r_trow;
                        end
                    end else begin
                        r_cur_col <= r_tcol + COL_W'(1);
                        r_cur_row <= r_trow;
                    end
                end
            end
            if (i_cmd.sweep_start) begin
                r_ptr <= '0;
            end else if (i_cmd.sweep_step) begin
                r_ptr <= r_ptr + ADDR_W'(1);
            end
            if (i_cmd.result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result) begin
            r_cell  <= cur_idx[tcw_pkg::CURSOR_W-1:0];
            r_scr_o <= r_scr;
            if (r_op == tcw_pkg::OP_READ) begin
                r_rch   <= r_rdata[tcw_pkg::CHAR_W-1:0];
                r_rattr <= r_rdata[tcw_pkg::CELL_DW-1:tcw_pkg::CHAR_W];
            end else begin
                r_rch   <= '0;
                r_rattr <= '0;
            end
        end
    end

    assign o_status.is_read    = (r_op == tcw_pkg::OP_READ);
    assign o_status.wraps      = col_last && row_last;
    assign o_status.sweep_last = (r_ptr == ADDR_W'(CELLS - 1));
    assign o_status.out_busy   = r_out_valid && !i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_cursor_cell    = r_cell;
    assign o_scrolled       = r_scr_o;
    assign o_read_character = r_rch;
    assign o_read_attribute = r_rattr;

endmodule

### rtl/text_console_writer_core.sv
// top level of the text console writer: controller plus datapath
//
// channel   direction  handshake            payload
// request   in         i_valid / o_ready    i_op i_character i_column i_line
//                                           i_use_position i_attribute
// result    out        o_valid / i_ready    o_cursor_cell o_scrolled
//                                           o_read_character o_read_attribute
// config    in         i_cfg_we             i_cfg_data (default attribute)
//
// a print or read request goes from acceptance to the result register through select,
// address multiply, memory access and result load; a new request waits for that load
// a print that passes the last cell scrolls the screen up one row before the result load,
// one cell per cycle through the separate read and write ports of the screen memory
// after reset the screen memory is cleared while o_ready is low
// a request is accepted while an earlier result still waits in the output register
module text_console_writer_core #(
    parameter int ROWS = tcw_pkg::DEF_ROWS,
    parameter int COLS = tcw_pkg::DEF_COLS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_op,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_character,
    input  logic [tcw_pkg::COLUMN_W-1:0]  i_column,
    input  logic [tcw_pkg::LINE_W-1:0]    i_line,
    input  logic                          i_use_position,
    input  logic [tcw_pkg::ATTR_W-1:0]    i_attribute,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [tcw_pkg::CURSOR_W-1:0]  o_cursor_cell,
    output logic                          o_scrolled,
    output logic [tcw_pkg::CHAR_W-1:0]    o_read_character,
    output logic [tcw_pkg::ATTR_W-1:0]    o_read_attribute
);

    tcw_pkg::t_cmd    cmd;
    tcw_pkg::t_status status;

    tcw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_ready  (o_ready),
        .o_cmd    (cmd)
    );

    tcw_dp #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_op             (i_op),
        .i_character      (i_character),
        .i_column         (i_column),
        .i_line           (i_line),
        .i_use_position   (i_use_position),
        .i_attribute      (i_attribute),
        .i_out_ready      (i_ready),
        .o_out_valid      (o_valid),
        .o_cursor_cell    (o_cursor_cell),
        .o_scrolled       (o_scrolled),
        .o_read_character (o_read_character),
        .o_read_attribute (o_read_attribute)
    );

endmodule
